// File: design/mjt_pkg.sv
package mjt_pkg;

   localparam int WORD_BITS = 64;
   localparam int PROD_BITS = 128;
   localparam int MAG_BITS = 63;
   localparam int SHIFT_BITS = 5;

   localparam int DIV_BITS = 16;
   localparam int QUO_BITS = 30;
   localparam int DIV_CNT_BITS = 5;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEPS_PER_MOVE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERSE_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INERTIA_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POSITION_GAIN  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VELOCITY_GAIN  = 3'd4;

   localparam logic [SHIFT_BITS-1:0] SH_Q30  = 5'd30;
   localparam logic [SHIFT_BITS-1:0] SH_Q16  = 5'd16;
   localparam logic [SHIFT_BITS-1:0] SH_GOAL = 5'd28;
   localparam logic [SHIFT_BITS-1:0] SH_T15  = 5'd3;

   localparam logic [WORD_BITS-1:0] PROD_LIMIT = 64'h1000_0000_0000_0000;
   localparam logic signed [WORD_BITS-1:0] DEG_TO_RAD = 64'sd74961321;
   localparam logic signed [WORD_BITS-1:0] HALF_Q30 = 64'sd536870912;
   localparam logic signed [WORD_BITS-1:0] EIGHTH_Q30 = 64'sd134217728;
   localparam logic [QUO_BITS:0] ONE_Q30 = 31'h4000_0000;

   typedef struct packed {
      logic                  start;
      logic [SHIFT_BITS-1:0] shamt;
   } mul_ctrl_type;

   function automatic logic signed [31:0] sat32(input logic signed [WORD_BITS-1:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// File: design/mjt_div.sv
module mjt_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mjt_pkg::DIV_BITS-1:0]        num,
   input  logic [mjt_pkg::DIV_BITS-1:0]        den,
   output logic                                done,
   output logic [mjt_pkg::QUO_BITS-1:0]        quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [mjt_pkg::DIV_BITS:0]         rem_ff, rem_in;
   logic [mjt_pkg::QUO_BITS-1:0]       quo_ff, quo_in;
   logic [mjt_pkg::DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [mjt_pkg::DIV_BITS:0]         rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      rem_sh = {rem_ff[mjt_pkg::DIV_BITS-1:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         rem_in = {1'b0, num};
         cnt_in = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den}) begin
            rem_in = rem_sh - {1'b0, den};
            quo_in = {quo_ff[mjt_pkg::QUO_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[mjt_pkg::QUO_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mjt_pkg::DIV_CNT_BITS'(mjt_pkg::QUO_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/mjt_mul.sv
module mjt_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mjt_pkg::mul_ctrl_type                  ctrl,
   input  logic signed [mjt_pkg::WORD_BITS-1:0]   op_a,
   input  logic signed [mjt_pkg::WORD_BITS-1:0]   op_b,
   output logic                                   done,
   output logic signed [mjt_pkg::WORD_BITS-1:0]   result
);

   logic                                  busy_ff, busy_in;
   logic                                  fin_ff, fin_in;
   logic                                  done_ff, done_in;
   logic [mjt_pkg::PROD_BITS-1:0]         acc_ff, acc_in;
   logic [mjt_pkg::PROD_BITS-1:0]         ash_ff, ash_in;
   logic [mjt_pkg::PROD_BITS-1:0]         rnd_ff, rnd_in;
   logic [mjt_pkg::MAG_BITS-1:0]          b_ff, b_in;
   logic                                  neg_ff, neg_in;
   logic [mjt_pkg::SHIFT_BITS-1:0]        sh_ff, sh_in;
   logic signed [mjt_pkg::WORD_BITS-1:0]  res_ff, res_in;
   logic [mjt_pkg::WORD_BITS-1:0]         mag_a, mag_b, qs;
   logic [mjt_pkg::PROD_BITS-1:0]         q;

   always_comb begin
      mag_a = op_a[mjt_pkg::WORD_BITS-1] ? mjt_pkg::WORD_BITS'(-op_a) : op_a;
      mag_b = op_b[mjt_pkg::WORD_BITS-1] ? mjt_pkg::WORD_BITS'(-op_b) : op_b;
      q = rnd_ff >> sh_ff;
      qs = (q > mjt_pkg::PROD_BITS'(mjt_pkg::PROD_LIMIT)) ? mjt_pkg::PROD_LIMIT
                                                          : q[mjt_pkg::WORD_BITS-1:0];
      busy_in = busy_ff;
      fin_in = fin_ff;
      done_in = 1'b0;
      acc_in = acc_ff;
      ash_in = ash_ff;
      rnd_in = rnd_ff;
      b_in = b_ff;
      neg_in = neg_ff;
      sh_in = sh_ff;
      res_in = res_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         fin_in = 1'b0;
         acc_in = '0;
         ash_in = mjt_pkg::PROD_BITS'(mag_a);
         b_in = mag_b[mjt_pkg::MAG_BITS-1:0];
         neg_in = op_a[mjt_pkg::WORD_BITS-1] ^ op_b[mjt_pkg::WORD_BITS-1];
         sh_in = ctrl.shamt;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
            rnd_in = acc_ff + (mjt_pkg::PROD_BITS'(1) << (sh_ff - 1'b1));
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + ash_ff;
            end
            ash_in = ash_ff << 1;
            b_in = b_ff >> 1;
         end
      end else if (fin_ff) begin
         fin_in = 1'b0;
         done_in = 1'b1;
         res_in = neg_ff ? -$signed(qs) : $signed(qs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      ash_ff <= ash_in;
      rnd_ff <= rnd_in;
      b_ff <= b_in;
      neg_ff <= neg_in;
      sh_ff <= sh_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule

// File: design/min_jerk_trajectory_torque_control_unit.sv
// Single-joint minimum-jerk trajectory generator with computed-torque PD. A set-goal word
// (req_type 1) runs one product and gives no response; a tick word (req_type 0) gives
// one response word after a restoring division for the path fraction, then fourteen
// products on one shared bit-serial multiplier, each stepping through the bits of its
// second operand (at most 33). The response sits in an output register, so the next word
// may be sent while it waits to be taken. Write configuration only while the block is
// idle; csr_ready is always high.
module min_jerk_trajectory_torque_control_unit #(
   parameter int STEP_BITS = 16,
   parameter int ANGLE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic signed [31:0]                   req_goal_degrees,
   input  logic signed [31:0]                   req_measured_position,
   input  logic signed [31:0]                   req_measured_velocity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_position_ref,
   output logic signed [31:0]                   rsp_velocity_ref,
   output logic signed [31:0]                   rsp_accel_ref,
   output logic signed [31:0]                   rsp_torque_cmd,
   output logic                                 rsp_move_done,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mjt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mjt_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int CW = ((STEP_BITS > 16) ? STEP_BITS : 16) + 1;
   localparam int WB = mjt_pkg::WORD_BITS;
   localparam logic signed [WB-1:0] ANG_HI = (64'sd1 <<< (ANGLE_BITS - 1)) - 64'sd1;
   localparam logic signed [WB-1:0] ANG_LO = -ANG_HI - 64'sd1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_MUL  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      OP_U2, OP_U3, OP_U4, OP_U5, OP_T15, OP_TP, OP_TV, OP_TV2,
      OP_TA, OP_TA2, OP_TA3, OP_PE, OP_VE, OP_TQ, OP_GOAL
   } op_type;

   function automatic logic signed [ANGLE_BITS-1:0] sat_angle(input logic signed [WB-1:0] x);
      logic signed [WB-1:0] r;
      r = (x > ANG_HI) ? ANG_HI : ((x < ANG_LO) ? ANG_LO : x);
      return ANGLE_BITS'(r);
   endfunction

   state_type                       state_ff, state_in;
   op_type                          op_ff, op_in;
   logic                            issued_ff, issued_in;
   logic [15:0]                     spm_ff, spm_in;
   logic [31:0]                     ip_ff, ip_in, ig_ff, ig_in, kp_ff, kp_in, kd_ff, kd_in;
   logic [STEP_BITS-1:0]            step_ff, step_in;
   logic signed [ANGLE_BITS-1:0]    so_ff, so_in, travel_ff, travel_in;
   logic signed [31:0]              goal_ff, goal_in, mp_ff, mp_in, mv_ff, mv_in;
   logic signed [WB-1:0]            u_ff, u_in, u2_ff, u2_in, u3_ff, u3_in, u4_ff, u4_in;
   logic signed [WB-1:0]            u5_ff, u5_in, t15_ff, t15_in, tp_ff, tp_in;
   logic signed [WB-1:0]            tv_ff, tv_in, ta_ff, ta_in, pe_ff, pe_in;
   logic signed [WB-1:0]            ve_ff, ve_in, tq_ff, tq_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]              pos_ff, pos_in, vel_ff, vel_in, acc_ff, acc_in;
   logic signed [31:0]              trq_ff, trq_in;
   logic                            mdone_ff, mdone_in;

   logic                            div_start, div_done;
   logic [mjt_pkg::QUO_BITS-1:0]    div_q;
   logic [mjt_pkg::DIV_BITS-1:0]    div_num;
   mjt_pkg::mul_ctrl_type           mul_ctrl;
   logic                            mul_done;
   logic signed [WB-1:0]            mul_res, mul_a, mul_b;
   logic [mjt_pkg::SHIFT_BITS-1:0]  mul_sh;

   logic [CW-1:0]                   step_ext, spm_ext, cmax_ext, end_ext, step_inc;
   logic                            at_end, done_w, load;
   logic [mjt_pkg::QUO_BITS:0]      s_q;
   logic signed [WB-1:0]            so_ext, travel_ext, p_w, v_w, a_w, inner_w;
   logic signed [31:0]              pref_w, vref_w, aref_w, torque_w;

   mjt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (spm_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   mjt_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mul_ctrl),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   always_comb begin
      step_ext = CW'(step_ff);
      spm_ext = CW'(spm_ff);
      cmax_ext = CW'({STEP_BITS{1'b1}});
      at_end = (spm_ff == '0) || (step_ext >= spm_ext);
      end_ext = (spm_ext < cmax_ext) ? spm_ext : cmax_ext;
      step_inc = (step_ext < cmax_ext) ? CW'(step_ext + 1'b1) : step_ext;
      done_w = step_inc >= end_ext;
      div_num = mjt_pkg::DIV_BITS'(step_ff);
      s_q = at_end ? mjt_pkg::ONE_Q30 : {1'b0, div_q};
      so_ext = WB'(so_ff);
      travel_ext = WB'(travel_ff);
      p_w = 64'sd6 * u5_ff - 64'sd5 * u3_ff + t15_ff + mjt_pkg::HALF_Q30;
      v_w = 64'sd30 * u4_ff - 64'sd15 * u2_ff + 64'sd15 * mjt_pkg::EIGHTH_Q30;
      a_w = 64'sd120 * u3_ff - 64'sd30 * u_ff;
      pref_w = mjt_pkg::sat32(so_ext + tp_ff);
      vref_w = mjt_pkg::sat32(tv_ff);
      aref_w = mjt_pkg::sat32(ta_ff);
      torque_w = mjt_pkg::sat32(tq_ff);
      inner_w = WB'(aref_w) + pe_ff + ve_ff;
   end

   always_comb begin
      case (op_ff)
         OP_U2:   begin mul_a = u_ff;       mul_b = u_ff;  mul_sh = mjt_pkg::SH_Q30; end
         OP_U3:   begin mul_a = u2_ff;      mul_b = u_ff;  mul_sh = mjt_pkg::SH_Q30; end
         OP_U4:   begin mul_a = u2_ff;      mul_b = u2_ff; mul_sh = mjt_pkg::SH_Q30; end
         OP_U5:   begin mul_a = u4_ff;      mul_b = u_ff;  mul_sh = mjt_pkg::SH_Q30; end
         OP_T15:  begin mul_a = u_ff;       mul_b = 64'sd15; mul_sh = mjt_pkg::SH_T15; end
         OP_TP:   begin mul_a = travel_ext; mul_b = p_w;   mul_sh = mjt_pkg::SH_Q30; end
         OP_TV:   begin mul_a = travel_ext; mul_b = v_w;   mul_sh = mjt_pkg::SH_Q30; end
         OP_TV2:  begin mul_a = tv_ff; mul_b = WB'(ip_ff); mul_sh = mjt_pkg::SH_Q16; end
         OP_TA:   begin mul_a = travel_ext; mul_b = a_w;   mul_sh = mjt_pkg::SH_Q30; end
         OP_TA2:  begin mul_a = ta_ff; mul_b = WB'(ip_ff); mul_sh = mjt_pkg::SH_Q16; end
         OP_TA3:  begin mul_a = ta_ff; mul_b = WB'(ip_ff); mul_sh = mjt_pkg::SH_Q16; end
         OP_PE: begin
            mul_a = WB'(pref_w) - WB'(mp_ff);
            mul_b = WB'(kp_ff);
            mul_sh = mjt_pkg::SH_Q16;
         end
         OP_VE: begin
            mul_a = WB'(vref_w) - WB'(mv_ff);
            mul_b = WB'(kd_ff);
            mul_sh = mjt_pkg::SH_Q16;
         end
         OP_TQ:   begin mul_a = inner_w; mul_b = WB'(ig_ff); mul_sh = mjt_pkg::SH_Q16; end
         OP_GOAL: begin
            mul_a = WB'(goal_ff);
            mul_b = mjt_pkg::DEG_TO_RAD;
            mul_sh = mjt_pkg::SH_GOAL;
         end
         default: begin mul_a = '0; mul_b = '0; mul_sh = mjt_pkg::SH_Q16; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      issued_in = issued_ff;
      step_in = step_ff;
      so_in = so_ff;
      travel_in = travel_ff;
      goal_in = goal_ff;
      mp_in = mp_ff;
      mv_in = mv_ff;
      u_in = u_ff;
      u2_in = u2_ff;
      u3_in = u3_ff;
      u4_in = u4_ff;
      u5_in = u5_ff;
      t15_in = t15_ff;
      tp_in = tp_ff;
      tv_in = tv_ff;
      ta_in = ta_ff;
      pe_in = pe_ff;
      ve_in = ve_ff;
      tq_in = tq_ff;
      div_start = 1'b0;
      mul_ctrl.start = 1'b0;
      mul_ctrl.shamt = mul_sh;
      load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               goal_in = req_goal_degrees;
               mp_in = req_measured_position;
               mv_in = req_measured_velocity;
               if (req_type) begin
                  op_in = OP_GOAL;
                  state_in = S_MUL;
               end else begin
                  div_start = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               u_in = $signed(WB'(s_q)) - mjt_pkg::HALF_Q30;
               op_in = OP_U2;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (!issued_ff) begin
               mul_ctrl.start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               op_in = op_type'(op_ff + 1'b1);
               case (op_ff)
                  OP_U2:  u2_in = mul_res;
                  OP_U3:  u3_in = mul_res;
                  OP_U4:  u4_in = mul_res;
                  OP_U5:  u5_in = mul_res;
                  OP_T15: t15_in = mul_res;
                  OP_TP:  tp_in = mul_res;
                  OP_TV:  tv_in = mul_res;
                  OP_TV2: tv_in = mul_res;
                  OP_TA:  ta_in = mul_res;
                  OP_TA2: ta_in = mul_res;
                  OP_TA3: ta_in = mul_res;
                  OP_PE:  pe_in = mul_res;
                  OP_VE:  ve_in = mul_res;
                  OP_TQ: begin
                     tq_in = mul_res;
                     state_in = S_OUT;
                  end
                  OP_GOAL: begin
                     travel_in = sat_angle(mul_res - so_ext);
                     step_in = '0;
                     state_in = S_IDLE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load = 1'b1;
               state_in = S_IDLE;
               if (done_w) begin
                  step_in = STEP_BITS'(end_ext);
                  so_in = sat_angle(WB'(pref_w));
                  travel_in = '0;
               end else begin
                  step_in = STEP_BITS'(step_inc);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      spm_in = spm_ff;
      ip_in = ip_ff;
      ig_in = ig_ff;
      kp_in = kp_ff;
      kd_in = kd_ff;
      if (csr_valid) begin
         case (csr_index)
            mjt_pkg::CSR_STEPS_PER_MOVE: spm_in = csr_data[15:0];
            mjt_pkg::CSR_INVERSE_PERIOD: ip_in = csr_data;
            mjt_pkg::CSR_INERTIA_GAIN:   ig_in = csr_data;
            mjt_pkg::CSR_POSITION_GAIN:  kp_in = csr_data;
            mjt_pkg::CSR_VELOCITY_GAIN:  kd_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pos_in = pos_ff;
      vel_in = vel_ff;
      acc_in = acc_ff;
      trq_in = trq_ff;
      mdone_in = mdone_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         pos_in = pref_w;
         vel_in = vref_w;
         acc_in = aref_w;
         trq_in = torque_w;
         mdone_in = done_w;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_U2;
         issued_ff <= 1'b0;
         spm_ff <= 16'd1000;
         ip_ff <= 32'd65536;
         ig_ff <= 32'd65536;
         kp_ff <= 32'd65536;
         kd_ff <= 32'd65536;
         step_ff <= '0;
         so_ff <= '0;
         travel_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         issued_ff <= issued_in;
         spm_ff <= spm_in;
         ip_ff <= ip_in;
         ig_ff <= ig_in;
         kp_ff <= kp_in;
         kd_ff <= kd_in;
         step_ff <= step_in;
         so_ff <= so_in;
         travel_ff <= travel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      goal_ff <= goal_in;
      mp_ff <= mp_in;
      mv_ff <= mv_in;
      u_ff <= u_in;
      u2_ff <= u2_in;
      u3_ff <= u3_in;
      u4_ff <= u4_in;
      u5_ff <= u5_in;
      t15_ff <= t15_in;
      tp_ff <= tp_in;
      tv_ff <= tv_in;
      ta_ff <= ta_in;
      pe_ff <= pe_in;
      ve_ff <= ve_in;
      tq_ff <= tq_in;
      pos_ff <= pos_in;
      vel_ff <= vel_in;
      acc_ff <= acc_in;
      trq_ff <= trq_in;
      mdone_ff <= mdone_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_position_ref = pos_ff;
   assign rsp_velocity_ref = vel_ff;
   assign rsp_accel_ref = acc_ff;
   assign rsp_torque_cmd = trq_ff;
   assign rsp_move_done = mdone_ff;

   mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_MUL)
      else $error("multiplier finished outside multiply phase");

   div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside divide phase");

   load_gives_word: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("finished tick produced no response word");

   end_zeros_travel: assert property (@(posedge clock) disable iff (reset)
      (load && done_w) |=> (travel_ff == '0) && (state_ff == S_IDLE))
      else $error("travel not cleared at move end");

endmodule

// File: tb/mjt_checker.sv
module mjt_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_type,
   input  logic signed [31:0] req_goal_degrees,
   input  logic signed [31:0] req_measured_position,
   input  logic signed [31:0] req_measured_velocity,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_position_ref,
   input  logic signed [31:0] rsp_velocity_ref,
   input  logic signed [31:0] rsp_accel_ref,
   input  logic signed [31:0] rsp_torque_cmd,
   input  logic               rsp_move_done,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [mjt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mjt_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_S = longint'(1) << 30;
   localparam longint HALF_S = longint'(1) << 29;
   localparam longint STEP_MAX = 65535;

   typedef struct {
      logic signed [31:0] position_ref;
      logic signed [31:0] velocity_ref;
      logic signed [31:0] accel_ref;
      logic signed [31:0] torque_cmd;
      logic               move_done;
   } traj_word_type;

   traj_word_type traj_q[$];

   logic [15:0] steps_per_move;
   logic [31:0] inverse_period, inertia_gain, position_gain, velocity_gain;
   longint      step_count, start_offset, travel;

   function automatic longint round_mul(longint a, longint b, int n);
      logic [127:0] ma, mb, pr;
      bit neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? 128'(-a) : 128'(a);
      mb = (b < 0) ? 128'(-b) : 128'(b);
      pr = (ma * mb + (128'd1 << (n - 1))) >> n;
      if (pr > (128'd1 << 60)) pr = 128'd1 << 60;
      return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   task automatic advance_trajectory(input logic signed [31:0] mp, input logic signed [31:0] mv);
      longint s, u, u2, u3, u4, u5, p, v, a, ip, pref, vref, aref, inner, trq, last;
      traj_word_type w;
      ip = longint'(inverse_period);
      if (steps_per_move == 0 || step_count >= steps_per_move) s = ONE_S;
      else s = (step_count << 30) / longint'(steps_per_move);
      u = s - HALF_S;
      u2 = round_mul(u, u, 30);
      u3 = round_mul(u2, u, 30);
      u4 = round_mul(u2, u2, 30);
      u5 = round_mul(u4, u, 30);
      p = 6 * u5 - 5 * u3 + round_mul(u, 15, 3) + HALF_S;
      v = 30 * u4 - 15 * u2 + 15 * (ONE_S / 8);
      a = 120 * u3 - 30 * u;
      pref = clip32(start_offset + round_mul(travel, p, 30));
      vref = clip32(round_mul(round_mul(travel, v, 30), ip, 16));
      aref = clip32(round_mul(round_mul(round_mul(travel, a, 30), ip, 16), ip, 16));
      inner = aref + round_mul(pref - longint'(mp), longint'(position_gain), 16)
                   + round_mul(vref - longint'(mv), longint'(velocity_gain), 16);
      trq = clip32(round_mul(inner, longint'(inertia_gain), 16));
      last = (steps_per_move < STEP_MAX) ? longint'(steps_per_move) : STEP_MAX;
      if (step_count < STEP_MAX) step_count++;
      w.move_done = step_count >= last;
      if (w.move_done) begin
         step_count = last;
         start_offset = pref;
         travel = 0;
      end
      w.position_ref = pref[31:0];
      w.velocity_ref = vref[31:0];
      w.accel_ref = aref[31:0];
      w.torque_cmd = trq[31:0];
      traj_q = {traj_q, w};
   endtask

   always @(posedge clock) begin
      traj_word_type w;
      if (reset) begin
         steps_per_move = 16'd1000;
         inverse_period = 32'd65536;
         inertia_gain = 32'd65536;
         position_gain = 32'd65536;
         velocity_gain = 32'd65536;
         step_count = 0;
         start_offset = 0;
         travel = 0;
         traj_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mjt_pkg::CSR_STEPS_PER_MOVE: steps_per_move = csr_data[15:0];
               mjt_pkg::CSR_INVERSE_PERIOD: inverse_period = csr_data;
               mjt_pkg::CSR_INERTIA_GAIN:   inertia_gain = csr_data;
               mjt_pkg::CSR_POSITION_GAIN:  position_gain = csr_data;
               mjt_pkg::CSR_VELOCITY_GAIN:  velocity_gain = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (traj_q.size() == 0) begin
               $error("unexpected response word");
               fail_count <= fail_count + 1;
            end else begin
               w = traj_q.pop_front();
               if (w.position_ref !== rsp_position_ref ||
                   w.velocity_ref !== rsp_velocity_ref ||
                   w.accel_ref !== rsp_accel_ref ||
                   w.torque_cmd !== rsp_torque_cmd ||
                   w.move_done !== rsp_move_done)
                  fail_count <= fail_count + 1;
               if (w.position_ref !== rsp_position_ref)
                  $error("position_ref exp %0d got %0d", w.position_ref, rsp_position_ref);
               if (w.velocity_ref !== rsp_velocity_ref)
                  $error("velocity_ref exp %0d got %0d", w.velocity_ref, rsp_velocity_ref);
               if (w.accel_ref !== rsp_accel_ref)
                  $error("accel_ref exp %0d got %0d", w.accel_ref, rsp_accel_ref);
               if (w.torque_cmd !== rsp_torque_cmd)
                  $error("torque_cmd exp %0d got %0d", w.torque_cmd, rsp_torque_cmd);
               if (w.move_done !== rsp_move_done)
                  $error("move_done exp %0d got %0d", w.move_done, rsp_move_done);
            end
         end
         if (req_valid && req_ready) begin
            if (req_type) begin
               travel = clip32(round_mul(longint'(req_goal_degrees),
                                         longint'(mjt_pkg::DEG_TO_RAD), 28)
                               - start_offset);
               step_count = 0;
            end else begin
               advance_trajectory(req_measured_position, req_measured_velocity);
            end
         end
      end
      pending <= traj_q.size();
   end
endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_type = 1'b0;
   logic signed [31:0] req_goal_degrees = '0, req_measured_position = '0;
   logic signed [31:0] req_measured_velocity = '0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [mjt_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [mjt_pkg::CSR_DATA_BITS-1:0] csr_data = '0;
   logic req_ready, rsp_valid, rsp_move_done, csr_ready;
   logic signed [31:0] rsp_position_ref, rsp_velocity_ref, rsp_accel_ref, rsp_torque_cmd;
   int fail_count, pending;
   int send_idle = 21, recv_idle = 65;

   always #6 clock = ~clock;

   min_jerk_trajectory_torque_control_unit u_dut (.*);

   mjt_checker u_chk (.*);

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   function automatic logic [31:0] pick_angle(int span);
      if ($urandom_range(9) == 0) return $urandom;
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic send_word(logic kind, logic [31:0] g, logic [31:0] p, logic [31:0] v);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_goal_degrees <= g;
      req_measured_position <= p;
      req_measured_velocity <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic tick_word();
      send_word(1'b0, $urandom, pick_angle(1 << 22), pick_angle(1 << 22));
   endtask

   task automatic write_csr(logic [mjt_pkg::CSR_INDEX_BITS-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_gains(logic [15:0] n, logic [31:0] ip, logic [31:0] ki,
                            logic [31:0] kp, logic [31:0] kd);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      write_csr(mjt_pkg::CSR_STEPS_PER_MOVE, {16'd0, n});
      write_csr(mjt_pkg::CSR_INVERSE_PERIOD, ip);
      write_csr(mjt_pkg::CSR_INERTIA_GAIN, ki);
      write_csr(mjt_pkg::CSR_POSITION_GAIN, kp);
      write_csr(mjt_pkg::CSR_VELOCITY_GAIN, kd);
      write_csr('1, $urandom);
   endtask

   initial begin
      #60_000_000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      int n, steps;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_gains(16'd3, 32'd65536, 32'd65536, 32'd65536, 32'd65536);
      send_word(1'b0, 32'd0, 32'd0, 32'd0);
      send_word(1'b1, 32'h7FFF_FFFF, 32'd0, 32'd0);
      send_word(1'b0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(1'b0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      repeat (3) send_word(1'b0, 32'd0, 32'd0, 32'd0);
      send_word(1'b1, 32'h8000_0000, 32'd0, 32'd0);
      repeat (4) send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(1'b1, 32'd90 << 16, 32'd0, 32'd0);
      send_word(1'b0, 32'd0, 32'd0, 32'd0);
      set_gains(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(1'b0, 32'd0, 32'd0, 32'd0);
      send_word(1'b1, 32'd45 << 16, 32'd0, 32'd0);
      repeat (2) send_word(1'b0, 32'd0, 32'h8000_0000, 32'h8000_0000);
      set_gains(16'd0, 32'd1, 32'd0, 32'd0, 32'd0);
      send_word(1'b1, 32'hFFB0_0000, 32'd0, 32'd0);
      repeat (2) send_word(1'b0, 32'd0, 32'h7FFF_FFFF, 32'h0000_0001);

      for (int ph = 0; ph < 6; ph++) begin
         send_idle = (ph < 2) ? 21 : (ph < 4) ? 65 : 0;
         recv_idle = (ph < 2) ? 65 : (ph < 4) ? 21 : 0;
         steps = (ph == 1) ? 65535 : $urandom_range(1, 12);
         case (ph)
            1: set_gains(16'(steps), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            3: set_gains(16'(steps), 32'd1, 32'd0, 32'd0, 32'd0);
            default: set_gains(16'(steps), $urandom_range(1 << 14, 1 << 18),
                               $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18),
                               $urandom_range(0, 1 << 18));
         endcase
         n = 0;
         while (n < 225) begin
            if ($urandom_range(99) < 85) begin
               send_word(1'b1, pick_angle(180 << 16), $urandom, $urandom);
               n++;
               repeat ($urandom_range(1, (steps + 3 < 40) ? steps + 3 : 40)) begin
                  tick_word();
                  n++;
               end
            end else begin
               send_word(1'($urandom_range(1)), $urandom, $urandom, $urandom);
               n++;
            end
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
